@@ rtl/core/queue_machine_instruction_executor_macros.svh @@
// Assertion macros for the queue machine executor
`ifndef QUEUE_MACHINE_INSTRUCTION_EXECUTOR_MACROS_SVH
`define QUEUE_MACHINE_INSTRUCTION_EXECUTOR_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define QMX_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check an implication whose consequent is due in the next cycle
`define QMX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/qmx_pkg.sv @@
// ----------------------------------------------------------------------------
// qmx_pkg
// Shared types and codes for the queue machine executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qmx_pkg;

    localparam int QueueDepth = 256;
    localparam int QAW        = $clog2(QueueDepth);
    localparam int RegCount   = 26;
    localparam int RAW        = 5;

    localparam logic [4:0] OP_PUSH   = 5'd0;
    localparam logic [4:0] OP_ADD    = 5'd1;
    localparam logic [4:0] OP_SUB    = 5'd2;
    localparam logic [4:0] OP_MUL    = 5'd3;
    localparam logic [4:0] OP_DIV    = 5'd4;
    localparam logic [4:0] OP_MOD    = 5'd5;
    localparam logic [4:0] OP_STORE  = 5'd6;
    localparam logic [4:0] OP_LOAD   = 5'd7;
    localparam logic [4:0] OP_PRINTQ = 5'd8;
    localparam logic [4:0] OP_PRINTR = 5'd9;
    localparam logic [4:0] OP_CHARQ  = 5'd10;
    localparam logic [4:0] OP_CHARR  = 5'd11;
    localparam logic [4:0] OP_JUMP   = 5'd12;
    localparam logic [4:0] OP_JZ     = 5'd13;
    localparam logic [4:0] OP_JEQ    = 5'd14;
    localparam logic [4:0] OP_JGT    = 5'd15;
    localparam logic [4:0] OP_QUIT   = 5'd16;

    localparam logic [1:0] FLT_NONE      = 2'd0;
    localparam logic [1:0] FLT_UNDERFLOW = 2'd1;
    localparam logic [1:0] FLT_OVERFLOW  = 2'd2;

    // instruction classes sorted out by the front end
    localparam logic [2:0] CLS_NOP    = 3'd0;
    localparam logic [2:0] CLS_PUSH   = 3'd1;
    localparam logic [2:0] CLS_ARITH  = 3'd2;
    localparam logic [2:0] CLS_POP1   = 3'd3;
    localparam logic [2:0] CLS_REGRD  = 3'd4;
    localparam logic [2:0] CLS_BRANCH = 3'd5;
    localparam logic [2:0] CLS_QUIT   = 3'd6;

    typedef struct packed {
        logic [2:0]  cls;
        logic [4:0]  op;
        logic [15:0] imm;
        logic [4:0]  r1;
        logic [4:0]  r2;
    } instr_t;

    typedef struct packed {
        logic        print_valid;
        logic        print_is_char;
        logic [15:0] print_value;
        logic        branch_taken;
        logic        halted;
        logic [1:0]  fault;
    } result_t;

endpackage

@@ rtl/core/qmx_front.sv @@
// ----------------------------------------------------------------------------
// qmx_front
// Accept instructions, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "queue_machine_instruction_executor_macros.svh"

module qmx_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [4:0]        in_op,
    input  logic [15:0]       in_imm,
    input  logic [4:0]        in_r1,
    input  logic [4:0]        in_r2,
    output logic              q_valid,
    input  logic              q_ready,
    output qmx_pkg::instr_t   q_instr
);

    qmx_pkg::instr_t slot_reg [2];
    logic            rd_ptr_reg, wr_ptr_reg;
    logic [1:0]      cnt_reg;
    logic [2:0]      cls;
    logic            push, pop;

    always_comb begin
        unique case (in_op)
            qmx_pkg::OP_PUSH, qmx_pkg::OP_LOAD: cls = qmx_pkg::CLS_PUSH;
            qmx_pkg::OP_ADD, qmx_pkg::OP_SUB, qmx_pkg::OP_MUL,
            qmx_pkg::OP_DIV, qmx_pkg::OP_MOD: cls = qmx_pkg::CLS_ARITH;
            qmx_pkg::OP_STORE, qmx_pkg::OP_PRINTQ,
            qmx_pkg::OP_CHARQ: cls = qmx_pkg::CLS_POP1;
            qmx_pkg::OP_PRINTR, qmx_pkg::OP_CHARR: cls = qmx_pkg::CLS_REGRD;
            qmx_pkg::OP_JUMP, qmx_pkg::OP_JZ, qmx_pkg::OP_JEQ,
            qmx_pkg::OP_JGT: cls = qmx_pkg::CLS_BRANCH;
            qmx_pkg::OP_QUIT: cls = qmx_pkg::CLS_QUIT;
            default: cls = qmx_pkg::CLS_NOP;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_instr  = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{cls: cls, op: in_op, imm: in_imm,
                                      r1: in_r1, r2: in_r2};
        end
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    `QMX_ASSERT_IMP(a_no_overfill, aclk, aresetn, 1'b1, cnt_reg <= 2'd2)
    `QMX_ASSERT_NEXT(a_push_counts, aclk, aresetn, push && !pop, cnt_reg != 2'd0)

endmodule

@@ rtl/core/qmx_divider.sv @@
// ----------------------------------------------------------------------------
// qmx_divider
// Restoring 16-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "queue_machine_instruction_executor_macros.svh"

module qmx_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient,
    output logic [15:0] remainder
);

    logic [15:0] quo_reg, den_reg;
    logic [16:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [16:0] trial;
    logic [16:0] shifted;

    assign shifted   = {rem_reg[15:0], quo_reg[15]};
    assign trial     = shifted - {1'b0, den_reg};
    assign quotient  = quo_reg;
    assign remainder = rem_reg[15:0];
    assign done      = busy_reg && (cnt_reg == 5'd0);

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg && cnt_reg != 5'd0) begin
            if (!trial[16]) begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[14:0], 1'b1};
            end else begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd16;
        end else if (busy_reg) begin
            if (cnt_reg == 5'd0) busy_reg <= 1'b0;
            else cnt_reg <= cnt_reg - 5'd1;
        end
    end

    `QMX_ASSERT_NEXT(a_start_busy, aclk, aresetn, start, busy_reg && cnt_reg == 5'd16)

endmodule

@@ rtl/core/qmx_back.sv @@
// ----------------------------------------------------------------------------
// qmx_back
// Execute queued instructions against the value queue and register file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "queue_machine_instruction_executor_macros.svh"

module qmx_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  qmx_pkg::instr_t   q_instr,
    output logic              res_valid,
    input  logic              res_ready,
    output qmx_pkg::result_t  res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD_A  = 3'd1;
    localparam logic [2:0] ST_RD_B  = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]            state_reg;
    qmx_pkg::instr_t       ins_reg;
    logic [15:0]           mem [qmx_pkg::QueueDepth];
    logic [15:0]           rd_data_reg;
    logic [qmx_pkg::QAW-1:0] head_reg, tail_reg;
    logic [qmx_pkg::QAW:0]   fill_reg;
    logic [15:0]           regs_reg [qmx_pkg::RegCount];
    logic                  halt_reg;
    logic [15:0]           a_reg, b_reg, wval_reg;
    logic                  do_push_reg;
    qmx_pkg::result_t      res_reg;
    logic [15:0]           r1v, r2v;
    logic [15:0]           mul_lo;
    logic                  div_start, div_done;
    logic [15:0]           div_q, div_r;
    logic                  rd_en;

    assign r1v = (ins_reg.r1 < 5'(qmx_pkg::RegCount)) ? regs_reg[ins_reg.r1] : 16'd0;
    assign r2v = (ins_reg.r2 < 5'(qmx_pkg::RegCount)) ? regs_reg[ins_reg.r2] : 16'd0;
    assign mul_lo = 16'(32'(a_reg) * 32'(b_reg));

    assign q_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;
    assign div_start = (state_reg == ST_EXEC) &&
                       (ins_reg.op == qmx_pkg::OP_DIV || ins_reg.op == qmx_pkg::OP_MOD);
    assign rd_en     = (state_reg == ST_RD_A) || (state_reg == ST_RD_B);

    // the second operand is still in the read register when the divider starts
    qmx_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(a_reg), .divisor(rd_data_reg),
        .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    // queue memory: registered read at head, single write at tail
    always_ff @(posedge aclk) begin
        if (rd_en) rd_data_reg <= mem[head_reg];
        if (state_reg == ST_WRITE && do_push_reg) mem[tail_reg] <= wval_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            halt_reg  <= 1'b0;
            do_push_reg <= 1'b0;
            for (int i = 0; i < qmx_pkg::RegCount; i++) regs_reg[i] <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        ins_reg     <= q_instr;
                        do_push_reg <= 1'b0;
                        if (halt_reg) begin
                            res_reg   <= '{halted: 1'b1, default: '0};
                            state_reg <= ST_OUT;
                        end else begin
                            res_reg   <= '0;
                            state_reg <= ST_RD_A;
                        end
                    end
                end
                ST_RD_A: begin
                    // check for faults and start popping, or stage pushes and settle register prints, branches and quit
                    case (ins_reg.cls)
                        qmx_pkg::CLS_PUSH: begin
                            if (fill_reg == (qmx_pkg::QAW+1)'(qmx_pkg::QueueDepth)) begin
                                res_reg.fault <= qmx_pkg::FLT_OVERFLOW;
                                state_reg     <= ST_OUT;
                            end else begin
                                wval_reg    <= (ins_reg.op == qmx_pkg::OP_PUSH) ?
                                               ins_reg.imm : r1v;
                                do_push_reg <= 1'b1;
                                state_reg   <= ST_WRITE;
                            end
                        end
                        qmx_pkg::CLS_ARITH: begin
                            if (fill_reg < (qmx_pkg::QAW+1)'(2)) begin
                                res_reg.fault <= qmx_pkg::FLT_UNDERFLOW;
                                state_reg     <= ST_OUT;
                            end else begin
                                head_reg  <= head_reg + (qmx_pkg::QAW)'(1);
                                fill_reg  <= fill_reg - (qmx_pkg::QAW+1)'(1);
                                state_reg <= ST_RD_B;
                            end
                        end
                        qmx_pkg::CLS_POP1: begin
                            if (fill_reg == '0) begin
                                res_reg.fault <= qmx_pkg::FLT_UNDERFLOW;
                                state_reg     <= ST_OUT;
                            end else begin
                                head_reg  <= head_reg + (qmx_pkg::QAW)'(1);
                                fill_reg  <= fill_reg - (qmx_pkg::QAW+1)'(1);
                                state_reg <= ST_EXEC;
                            end
                        end
                        qmx_pkg::CLS_REGRD: begin
                            res_reg.print_valid <= 1'b1;
                            if (ins_reg.op == qmx_pkg::OP_CHARR) begin
                                res_reg.print_is_char <= 1'b1;
                                res_reg.print_value   <= {8'd0, r1v[7:0]};
                            end else begin
                                res_reg.print_value <= r1v;
                            end
                            state_reg <= ST_OUT;
                        end
                        qmx_pkg::CLS_BRANCH: begin
                            unique case (ins_reg.op)
                                qmx_pkg::OP_JUMP: res_reg.branch_taken <= 1'b1;
                                qmx_pkg::OP_JZ:   res_reg.branch_taken <= (r1v == 16'd0);
                                qmx_pkg::OP_JEQ:  res_reg.branch_taken <= (r1v == r2v);
                                default:          res_reg.branch_taken <= (r1v > r2v);
                            endcase
                            state_reg <= ST_OUT;
                        end
                        qmx_pkg::CLS_QUIT: begin
                            halt_reg       <= 1'b1;
                            res_reg.halted <= 1'b1;
                            state_reg      <= ST_OUT;
                        end
                        default: state_reg <= ST_OUT;
                    endcase
                end
                ST_RD_B: begin
                    a_reg     <= rd_data_reg;
                    head_reg  <= head_reg + (qmx_pkg::QAW)'(1);
                    fill_reg  <= fill_reg - (qmx_pkg::QAW+1)'(1);
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (ins_reg.cls == qmx_pkg::CLS_POP1) begin
                        if (ins_reg.op == qmx_pkg::OP_STORE) begin
                            if (ins_reg.r1 < 5'(qmx_pkg::RegCount))
                                regs_reg[ins_reg.r1] <= rd_data_reg;
                        end else begin
                            res_reg.print_valid <= 1'b1;
                            if (ins_reg.op == qmx_pkg::OP_CHARQ) begin
                                res_reg.print_is_char <= 1'b1;
                                res_reg.print_value   <= {8'd0, rd_data_reg[7:0]};
                            end else begin
                                res_reg.print_value <= rd_data_reg;
                            end
                        end
                        state_reg <= ST_OUT;
                    end else begin
                        b_reg     <= rd_data_reg;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // a_reg and b_reg now hold front and next values
                    do_push_reg <= 1'b1;
                    unique case (ins_reg.op)
                        qmx_pkg::OP_ADD: begin
                            wval_reg <= a_reg + b_reg; state_reg <= ST_WRITE;
                        end
                        qmx_pkg::OP_SUB: begin
                            wval_reg <= a_reg - b_reg; state_reg <= ST_WRITE;
                        end
                        qmx_pkg::OP_MUL: begin
                            wval_reg <= mul_lo; state_reg <= ST_WRITE;
                        end
                        default: begin
                            if (div_done) begin
                                if (b_reg == 16'd0) wval_reg <= 16'd0;
                                else wval_reg <= (ins_reg.op == qmx_pkg::OP_DIV) ?
                                                 div_q : div_r;
                                state_reg <= ST_WRITE;
                            end
                        end
                    endcase
                end
                ST_WRITE: begin
                    tail_reg  <= tail_reg + (qmx_pkg::QAW)'(1);
                    fill_reg  <= fill_reg + (qmx_pkg::QAW+1)'(1);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (res_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `QMX_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1,
                    fill_reg <= (qmx_pkg::QAW+1)'(qmx_pkg::QueueDepth))
    `QMX_ASSERT_IMP(a_fault_no_print, aclk, aresetn, res_valid && res.fault != qmx_pkg::FLT_NONE,
                    !res.print_valid)
    `QMX_ASSERT_NEXT(a_halt_sticky, aclk, aresetn, halt_reg, halt_reg)

endmodule

@@ rtl/core/queue_machine_instruction_executor.sv @@
// ----------------------------------------------------------------------------
// queue_machine_instruction_executor
// Executes decoded queue machine instructions, one result per instruction.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata (low bit up)                       | tuser
// s_      | in  | operation, immediate, first_reg, second_reg | -
// m_      | out | print_value, branch_taken, halted, fault    | print_valid, print_is_char
//
// One instruction at a time in the back end, from pickup to the result taken
// with m_tready high. Halted requests go straight out; register prints,
// branches, quit, nop and faults end in RD_A; push and load add WRITE,
// store and queue prints EXEC; arithmetic adds RD_B, EXEC, DIV and WRITE,
// divide and modulo also the 16-step divider loop. The front holds up to
// two classified requests. Reset clears queue pointers, registers and the
// halt flag; queue memory is left as it is. Either side may stall freely.
`timescale 1ns / 1ps
`include "queue_machine_instruction_executor_macros.svh"

module queue_machine_instruction_executor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operation[4:0], immediate[20:5], first_reg[25:21],
                                   // second_reg[30:26]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // print_value[15:0], branch_taken[16], halted[17],
                                   // fault[19:18]
    output logic [1:0]  m_tuser    // print_valid[0], print_is_char[1]
);

    logic             q_valid, q_ready;
    qmx_pkg::instr_t  q_instr;
    qmx_pkg::result_t res;

    // accept and classify
    qmx_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tdata[4:0]), .in_imm(s_tdata[20:5]),
        .in_r1(s_tdata[25:21]), .in_r2(s_tdata[30:26]),
        .q_valid(q_valid), .q_ready(q_ready), .q_instr(q_instr)
    );

    // execute and hold result until taken
    qmx_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_instr(q_instr),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {4'd0, res.fault, res.halted, res.branch_taken, res.print_value};
    assign m_tuser = {res.print_is_char, res.print_valid};

endmodule
